// File: src/twr_pkg.sv
// Shared constants and controller/datapath interface types for the ranging responder.
// No dependencies; every other file in src imports this package.
package twr_pkg;

  localparam int unsigned STAMP_BITS_DEF = 40;
  localparam int unsigned ANCHOR_SLOTS   = 4;
  localparam int unsigned TOF_BITS       = 40;
  localparam int unsigned MUL_STEPS      = 8;

  localparam logic [1:0]  FUNC_FRAME   = 2'd0;
  localparam logic [1:0]  FUNC_TX_DONE = 2'd1;
  localparam logic [1:0]  FUNC_TICK    = 2'd2;

  localparam logic [7:0]  MSG_POLL  = 8'd0;
  localparam logic [7:0]  MSG_RANGE = 8'd2;

  localparam logic [1:0]  KIND_ACK    = 2'd0;
  localparam logic [1:0]  KIND_REPORT = 2'd1;
  localparam logic [1:0]  KIND_FAILED = 2'd2;

  localparam logic [7:0]  ID_BASE = 8'hA0;

  localparam logic        REG_ANCHOR_INDEX = 1'b0;
  localparam logic        REG_IDLE_TIMEOUT = 1'b1;

  localparam logic [1:0]  ANCHOR_RESET  = 2'd1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd300;

  typedef struct packed {
    logic       accept;
    logic       prep;
    logic       mul_en;
    logic [2:0] mul_step;
    logic       acc_en;
    logic       abs_en;
    logic       div_en;
    logic       fin_en;
    logic       fail_en;
    logic       out_load;
  } twr_cmd_t;

  typedef struct packed {
    logic ev_result;
    logic ev_compute;
    logic sum_zero;
  } twr_status_t;

endpackage

// File: src/twr_ctrl.sv
// Sequencing controller: request handshake, compute sequence and output register valid.
// Depends on twr_pkg; drives commands into twr_dp and reads its status.
module twr_ctrl import twr_pkg::*; #(
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  input  twr_status_t status_i,
  output twr_cmd_t    cmd_o
);

  localparam int unsigned DIV_STEPS = 2 * STAMP_BITS;
  localparam int unsigned CW        = $clog2(DIV_STEPS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ABS  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_HOLD = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    cmd_o.mul_step = cnt_q[2:0];
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (status_i.ev_result) begin
            state_d = S_HOLD;
          end else if (status_i.ev_compute) begin
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CHK;
      end
      S_CHK: begin
        cnt_d = '0;
        if (status_i.sum_zero) begin
          cmd_o.fail_en = 1'b1;
          state_d       = S_HOLD;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = (cnt_q < CW'(MUL_STEPS));
        cmd_o.acc_en = (cnt_q != '0);
        cnt_d        = cnt_q + CW'(1);
        if (cnt_q == CW'(MUL_STEPS)) begin
          state_d = S_ABS;
        end
      end
      S_ABS: begin
        cmd_o.abs_en = 1'b1;
        cnt_d        = '0;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        cnt_d        = cnt_q + CW'(1);
        if (cnt_q == CW'(DIV_STEPS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin_en = 1'b1;
        state_d      = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/twr_dp.sv
// Datapath: configuration, exchange state, interval capture, split multiplier,
// signed accumulator, restoring divider and result/output registers. Depends on twr_pkg.
module twr_dp import twr_pkg::*; #(
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [15:0]           cfg_data_i,
  input  logic [1:0]            func_i,
  input  logic [7:0]            msg_id_i,
  input  logic [STAMP_BITS-1:0] local_time_i,
  input  logic [STAMP_BITS-1:0] tag_poll_sent_i,
  input  logic [STAMP_BITS-1:0] tag_range_sent_i,
  input  logic [STAMP_BITS-1:0] ack_rx_slot0_i,
  input  logic [STAMP_BITS-1:0] ack_rx_slot1_i,
  input  logic [STAMP_BITS-1:0] ack_rx_slot2_i,
  input  logic [STAMP_BITS-1:0] ack_rx_slot3_i,
  input  twr_cmd_t              cmd_i,
  output twr_status_t           status_o,
  output logic [1:0]            tx_kind_o,
  output logic [7:0]            source_id_o,
  output logic [TOF_BITS-1:0]   flight_time_o
);

  localparam int unsigned SB = STAMP_BITS;
  localparam int unsigned H  = (SB + 1) / 2;
  localparam int unsigned PW = 2 * H;
  localparam int unsigned AW = 2 * SB + 1;
  localparam int unsigned DW = 2 * SB;
  localparam int unsigned RW = SB + 2;

  logic [1:0]  anchor_q;
  logic [15:0] timeout_q;

  logic          expect_q, expect_d;
  logic          err_q, err_d;
  logic          last_ack_q, last_ack_d;
  logic [15:0]   idle_q, idle_d;
  logic [SB-1:0] poll_rx_q, poll_rx_d;
  logic [SB-1:0] ack_tx_q, ack_tx_d;

  logic [SB-1:0] rnd1_q, rnd2_q, rep1_q, rep2_q;
  logic [RW-1:0] sum_q;
  logic [PW-1:0] pp_q;
  logic [1:0]    pp_sh_q;
  logic          pp_neg_q;
  logic [AW-1:0] acc_q;
  logic [DW-1:0] dvd_q;
  logic [RW-1:0] rem_q;
  logic [TOF_BITS-1:0] quo_q;
  logic          neg_q;

  logic [1:0]          res_kind_q, out_kind_q;
  logic [7:0]          res_src_q, out_src_q;
  logic [TOF_BITS-1:0] res_tof_q, out_tof_q;

  logic [7:0]    src_id;
  logic [1:0]    slot;
  logic [SB-1:0] ack_rx;
  logic          is_frame, err_n;
  logic [15:0]   idle_inc;

  logic [SB-1:0] ma, mb;
  logic [H-1:0]  ah, bh;
  logic [PW-1:0] pp_d;
  logic [AW-1:0] term;
  logic [RW:0]   rs;
  logic          ge;

  assign src_id = ID_BASE + {6'd0, anchor_q};

  always_comb begin
    slot = anchor_q;
    if ({1'b0, anchor_q} >= 3'(ANCHOR_SLOTS)) begin
      slot = 2'(ANCHOR_SLOTS - 1);
    end
    case (slot)
      2'd0:    ack_rx = ack_rx_slot0_i;
      2'd1:    ack_rx = ack_rx_slot1_i;
      2'd2:    ack_rx = ack_rx_slot2_i;
      default: ack_rx = ack_rx_slot3_i;
    endcase
  end

  assign is_frame = (func_i == FUNC_FRAME);
  assign err_n    = err_q || (msg_id_i != (expect_q ? MSG_RANGE : MSG_POLL));
  assign idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;

  assign status_o.ev_result  = is_frame &&
                               ((msg_id_i == MSG_POLL) || ((msg_id_i == MSG_RANGE) && err_n));
  assign status_o.ev_compute = is_frame && (msg_id_i == MSG_RANGE) && !err_n;
  assign status_o.sum_zero   = (sum_q == '0);

  always_comb begin
    expect_d   = expect_q;
    err_d      = err_q;
    last_ack_d = last_ack_q;
    idle_d     = idle_q;
    poll_rx_d  = poll_rx_q;
    ack_tx_d   = ack_tx_q;
    if (cmd_i.accept) begin
      case (func_i)
        FUNC_TICK: begin
          if (idle_inc > timeout_q) begin
            expect_d = 1'b0;
            idle_d   = '0;
          end else begin
            idle_d = idle_inc;
          end
        end
        FUNC_TX_DONE: begin
          if (last_ack_q) begin
            ack_tx_d = local_time_i;
            idle_d   = '0;
          end
        end
        FUNC_FRAME: begin
          err_d = err_n;
          if (msg_id_i == MSG_POLL) begin
            err_d      = 1'b0;
            poll_rx_d  = local_time_i;
            expect_d   = 1'b1;
            last_ack_d = 1'b1;
            idle_d     = '0;
          end else if (msg_id_i == MSG_RANGE) begin
            expect_d   = 1'b0;
            idle_d     = '0;
            last_ack_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q   <= ANCHOR_RESET;
      timeout_q  <= TIMEOUT_RESET;
      expect_q   <= 1'b0;
      err_q      <= 1'b0;
      last_ack_q <= 1'b0;
      idle_q     <= '0;
      poll_rx_q  <= '0;
      ack_tx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ANCHOR_INDEX: anchor_q  <= cfg_data_i[1:0];
          REG_IDLE_TIMEOUT: timeout_q <= cfg_data_i;
          default: ;
        endcase
      end
      expect_q   <= expect_d;
      err_q      <= err_d;
      last_ack_q <= last_ack_d;
      idle_q     <= idle_d;
      poll_rx_q  <= poll_rx_d;
      ack_tx_q   <= ack_tx_d;
    end
  end

  always_comb begin
    ma   = cmd_i.mul_step[2] ? rep1_q : rnd1_q;
    mb   = cmd_i.mul_step[2] ? rep2_q : rnd2_q;
    ah   = cmd_i.mul_step[1] ? H'(ma >> H) : ma[H-1:0];
    bh   = cmd_i.mul_step[0] ? H'(mb >> H) : mb[H-1:0];
    pp_d = PW'(ah) * PW'(bh);
    case (pp_sh_q)
      2'd0:    term = AW'(pp_q);
      2'd1:    term = AW'(pp_q) << H;
      default: term = AW'(pp_q) << (2 * H);
    endcase
    rs = {rem_q, dvd_q[DW-1]};
    ge = (rs >= {1'b0, sum_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rnd1_q <= ack_rx - tag_poll_sent_i;
      rep1_q <= ack_tx_q - poll_rx_q;
      rnd2_q <= local_time_i - ack_tx_q;
      rep2_q <= tag_range_sent_i - ack_rx;
      if (msg_id_i == MSG_POLL) begin
        res_kind_q <= KIND_ACK;
        res_src_q  <= src_id;
      end else begin
        res_kind_q <= KIND_FAILED;
        res_src_q  <= '0;
      end
      res_tof_q <= '0;
    end
    if (cmd_i.prep) begin
      sum_q <= RW'(rnd1_q) + RW'(rnd2_q) + RW'(rep1_q) + RW'(rep2_q);
      acc_q <= '0;
    end
    if (cmd_i.mul_en) begin
      pp_q     <= pp_d;
      pp_sh_q  <= {1'b0, cmd_i.mul_step[1]} + {1'b0, cmd_i.mul_step[0]};
      pp_neg_q <= cmd_i.mul_step[2];
    end
    if (cmd_i.acc_en) begin
      acc_q <= pp_neg_q ? acc_q - term : acc_q + term;
    end
    if (cmd_i.abs_en) begin
      dvd_q <= acc_q[AW-1] ? DW'(-acc_q) : DW'(acc_q);
      neg_q <= acc_q[AW-1];
      rem_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.div_en) begin
      rem_q <= ge ? RW'(rs - {1'b0, sum_q}) : RW'(rs);
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[TOF_BITS-2:0], ge};
    end
    if (cmd_i.fail_en) begin
      res_kind_q <= KIND_FAILED;
      res_src_q  <= '0;
      res_tof_q  <= '0;
    end
    if (cmd_i.fin_en) begin
      res_kind_q <= KIND_REPORT;
      res_src_q  <= src_id;
      res_tof_q  <= neg_q ? -quo_q : quo_q;
    end
    if (cmd_i.out_load) begin
      out_kind_q <= res_kind_q;
      out_src_q  <= res_src_q;
      out_tof_q  <= res_tof_q;
    end
  end

  assign tx_kind_o     = out_kind_q;
  assign source_id_o   = out_src_q;
  assign flight_time_o = out_tof_q;

endmodule

// File: src/twr_anchor_ranging_responder.sv
// Anchor-side two-way ranging responder: top level joining twr_ctrl and twr_dp.
// Depends on twr_pkg, twr_ctrl and twr_dp.
//
// Takes one event per request: a received frame, a transmit-done or a millisecond tick.
// Ticks, transmit-done and frames other than POLL/RANGE yield no frame. A POLL yields a
// poll acknowledgement. A RANGE that fails (error seen or all intervals zero) yields a
// failure frame; a good RANGE computes (round1*round2 - reply1*reply2) / (sum of
// intervals) with an eight-step half-width multiplier and a one-bit-per-cycle divider.
// Events are accepted while a finished result waits at the output, but not while a
// RANGE computes or a new result waits to be loaded. Configuration is written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only while no request is in
// flight, as the block does not enforce this.
module twr_anchor_ranging_responder import twr_pkg::*; #(
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            func_i,
  input  logic [7:0]            msg_id_i,
  input  logic [STAMP_BITS-1:0] local_time_i,
  input  logic [STAMP_BITS-1:0] tag_poll_sent_i,
  input  logic [STAMP_BITS-1:0] tag_range_sent_i,
  input  logic [STAMP_BITS-1:0] ack_rx_slot0_i,
  input  logic [STAMP_BITS-1:0] ack_rx_slot1_i,
  input  logic [STAMP_BITS-1:0] ack_rx_slot2_i,
  input  logic [STAMP_BITS-1:0] ack_rx_slot3_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            tx_kind_o,
  output logic [7:0]            source_id_o,
  output logic [TOF_BITS-1:0]   flight_time_o
);

  twr_cmd_t    cmd;
  twr_status_t status;

  twr_ctrl #(
    .STAMP_BITS (STAMP_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  twr_dp #(
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (func_i),
    .msg_id_i         (msg_id_i),
    .local_time_i     (local_time_i),
    .tag_poll_sent_i  (tag_poll_sent_i),
    .tag_range_sent_i (tag_range_sent_i),
    .ack_rx_slot0_i   (ack_rx_slot0_i),
    .ack_rx_slot1_i   (ack_rx_slot1_i),
    .ack_rx_slot2_i   (ack_rx_slot2_i),
    .ack_rx_slot3_i   (ack_rx_slot3_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .tx_kind_o        (tx_kind_o),
    .source_id_o      (source_id_o),
    .flight_time_o    (flight_time_o)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("output register loaded while holding an untaken result");

  a_busy_after_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && status.ev_compute) |=> !in_ready_o)
    else $error("request accepted during ranging computation");

  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.prep, cmd.abs_en, cmd.div_en, cmd.fin_en, cmd.fail_en,
              cmd.out_load}))
    else $error("overlapping datapath phases");

  a_fail_on_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fail_en |-> status.sum_zero)
    else $error("range failed without zero divisor");

endmodule

// File: tb/twr_anchor_ranging_responder_tb.sv
// Testbench for the anchor-side two-way ranging responder: drives event requests,
// predicts every transmitted frame and checks each one field by field.
// Depends on twr_pkg and twr_anchor_ranging_responder.
`timescale 1ns / 100ps

module twr_anchor_ranging_responder_tb;
  import twr_pkg::*;

  localparam int unsigned SW           = STAMP_BITS_DEF;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]           func;
    logic [7:0]           msg;
    logic [SW-1:0]        now;
    logic [SW-1:0]        t_poll;
    logic [SW-1:0]        t_range;
    logic [3:0][SW-1:0]   slot;
  } ranging_evt_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          src;
    logic [TOF_BITS-1:0] tof;
  } tx_frame_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = 1'b0;
  logic [15:0]         cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          func_i = '0;
  logic [7:0]          msg_id_i = '0;
  logic [SW-1:0]       local_time_i = '0;
  logic [SW-1:0]       tag_poll_sent_i = '0;
  logic [SW-1:0]       tag_range_sent_i = '0;
  logic [SW-1:0]       ack_rx_slot0_i = '0;
  logic [SW-1:0]       ack_rx_slot1_i = '0;
  logic [SW-1:0]       ack_rx_slot2_i = '0;
  logic [SW-1:0]       ack_rx_slot3_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          tx_kind_o;
  logic [7:0]          source_id_o;
  logic [TOF_BITS-1:0] flight_time_o;

  twr_anchor_ranging_responder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .msg_id_i         (msg_id_i),
    .local_time_i     (local_time_i),
    .tag_poll_sent_i  (tag_poll_sent_i),
    .tag_range_sent_i (tag_range_sent_i),
    .ack_rx_slot0_i   (ack_rx_slot0_i),
    .ack_rx_slot1_i   (ack_rx_slot1_i),
    .ack_rx_slot2_i   (ack_rx_slot2_i),
    .ack_rx_slot3_i   (ack_rx_slot3_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tx_kind_o        (tx_kind_o),
    .source_id_o      (source_id_o),
    .flight_time_o    (flight_time_o)
  );

  // responder model state and configuration
  logic [1:0]    anchor_sel = ANCHOR_RESET;
  logic [15:0]   timeout_ms = TIMEOUT_RESET;
  logic          want_range = 1'b0;
  logic          err_seen = 1'b0;
  logic [SW-1:0] poll_rx = '0;
  logic [SW-1:0] ack_tx = '0;
  logic          ack_sent = 1'b0;
  logic [15:0]   idle_ms = '0;

  tx_frame_t     pending_frames[$];
  int unsigned   err_cnt = 0;
  int unsigned   sent_items = 0;
  int unsigned   snd_idle_pct = 0;
  int unsigned   rcv_stall_pct = 0;
  int unsigned   rcv_hold = 0;
  int unsigned   cycle_cnt = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rcv_hold != 0) begin
      rcv_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    tx_frame_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected frame kind %0d src %0h tof %0h", $time,
                 tx_kind_o, source_id_o, flight_time_o);
        err_cnt++;
      end else begin
        want = pending_frames.pop_front();
        if (tx_kind_o !== want.kind) begin
          $display("%0t: tx_kind expected %0d got %0d", $time, want.kind, tx_kind_o);
          err_cnt++;
        end
        if (source_id_o !== want.src) begin
          $display("%0t: source_id expected %0h got %0h", $time, want.src, source_id_o);
          err_cnt++;
        end
        if (flight_time_o !== want.tof) begin
          $display("%0t: flight_time expected %0h got %0h", $time, want.tof, flight_time_o);
          err_cnt++;
        end
      end
    end
  end

  function automatic logic [SW-1:0] rand_stamp();
    return SW'({$urandom(), $urandom()});
  endfunction

  function automatic ranging_evt_t random_evt();
    ranging_evt_t ev;
    int unsigned  pick;
    pick = $urandom_range(0, 5);
    ev.func = 2'($urandom_range(0, 3));
    ev.msg = (pick < 2) ? MSG_POLL : (pick < 4) ? MSG_RANGE : 8'($urandom_range(0, 255));
    ev.now = rand_stamp();
    ev.t_poll = rand_stamp();
    ev.t_range = rand_stamp();
    for (int i = 0; i < 4; i++) ev.slot[i] = rand_stamp();
    return ev;
  endfunction

  // advance the responder model by one accepted request
  task automatic apply_event(input ranging_evt_t ev);
    logic [SW-1:0]   arx, round1, reply1, round2, reply2;
    logic [SW+1:0]   div_sum;
    logic [2*SW-1:0] p_round, p_reply, quo;
    case (ev.func)
      FUNC_TICK: begin
        if (idle_ms != 16'hFFFF) idle_ms++;
        if (idle_ms > timeout_ms) begin
          want_range = 1'b0;
          idle_ms = '0;
        end
      end
      FUNC_TX_DONE: begin
        if (ack_sent) begin
          ack_tx = ev.now;
          idle_ms = '0;
        end
      end
      FUNC_FRAME: begin
        if (ev.msg != (want_range ? MSG_RANGE : MSG_POLL)) err_seen = 1'b1;
        if (ev.msg == MSG_POLL) begin
          err_seen = 1'b0;
          poll_rx = ev.now;
          want_range = 1'b1;
          ack_sent = 1'b1;
          idle_ms = '0;
          pending_frames.push_back('{KIND_ACK, ID_BASE + 8'(anchor_sel), '0});
        end else if (ev.msg == MSG_RANGE) begin
          want_range = 1'b0;
          idle_ms = '0;
          ack_sent = 1'b0;
          arx = ev.slot[anchor_sel];
          round1 = arx - ev.t_poll;
          reply1 = ack_tx - poll_rx;
          round2 = ev.now - ack_tx;
          reply2 = ev.t_range - arx;
          div_sum = {2'b00, round1} + {2'b00, round2} + {2'b00, reply1} + {2'b00, reply2};
          if (err_seen || div_sum == '0) begin
            pending_frames.push_back('{KIND_FAILED, 8'h00, '0});
          end else begin
            p_round = (2*SW)'(round1) * (2*SW)'(round2);
            p_reply = (2*SW)'(reply1) * (2*SW)'(reply2);
            if (p_round >= p_reply) quo = (p_round - p_reply) / (2*SW)'(div_sum);
            else quo = -((p_reply - p_round) / (2*SW)'(div_sum));
            pending_frames.push_back('{KIND_REPORT, ID_BASE + 8'(anchor_sel),
                                       TOF_BITS'(quo)});
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_event(input ranging_evt_t ev);
    if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    in_valid_i       <= 1'b1;
    func_i           <= ev.func;
    msg_id_i         <= ev.msg;
    local_time_i     <= ev.now;
    tag_poll_sent_i  <= ev.t_poll;
    tag_range_sent_i <= ev.t_range;
    ack_rx_slot0_i   <= ev.slot[0];
    ack_rx_slot1_i   <= ev.slot[1];
    ack_rx_slot2_i   <= ev.slot[2];
    ack_rx_slot3_i   <= ev.slot[3];
    do @(posedge clk_i); while (!in_ready_o);
    apply_event(ev);
    sent_items++;
  endtask

  // hold requests until every frame is out, then let trailing work finish
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [1:0] idx_val, input logic [15:0] tmo);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_ANCHOR_INDEX;
    cfg_data_i <= {14'd0, idx_val};
    @(posedge clk_i);
    cfg_idx_i  <= REG_IDLE_TIMEOUT;
    cfg_data_i <= tmo;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    anchor_sel = idx_val;
    timeout_ms = tmo;
  endtask

  task automatic send_frame(input logic [7:0] msg, input logic [SW-1:0] now);
    ranging_evt_t ev;
    ev = random_evt();
    ev.func = FUNC_FRAME;
    ev.msg = msg;
    ev.now = now;
    send_event(ev);
  endtask

  task automatic send_simple(input logic [1:0] func, input logic [SW-1:0] now);
    ranging_evt_t ev;
    ev = random_evt();
    ev.func = func;
    ev.now = now;
    send_event(ev);
  endtask

  // poll, transmit-done and range with consistent timestamps, plus some disorder
  task automatic run_exchange();
    ranging_evt_t  ev;
    logic [SW-1:0] tag_t, anc_t, rep1, rep2, flight;
    int unsigned   shape;
    shape = $urandom_range(0, 99);
    tag_t = rand_stamp();
    anc_t = rand_stamp();
    rep1 = SW'($urandom_range(100, 300000));
    rep2 = SW'($urandom_range(100, 300000));
    flight = SW'($urandom_range(0, 3000));
    send_frame(MSG_POLL, anc_t);
    repeat ($urandom_range(0, 3)) send_simple(FUNC_TICK, rand_stamp());
    send_simple(FUNC_TX_DONE, anc_t + rep1);
    if (shape < 8) send_event(random_evt());
    if (shape >= 8 && shape < 14) repeat ($urandom_range(1, 4)) send_simple(FUNC_TICK, '0);
    ev = random_evt();
    ev.func = FUNC_FRAME;
    ev.msg = MSG_RANGE;
    if (shape < 85) begin
      ev.t_poll = tag_t;
      ev.slot[anchor_sel] = tag_t + rep1 + 2 * flight;
      ev.t_range = ev.slot[anchor_sel] + rep2;
      ev.now = anc_t + rep1 + rep2 + 2 * flight + SW'($urandom_range(0, 40)) - SW'(20);
    end
    send_event(ev);
    if (shape >= 90) send_simple(FUNC_TX_DONE, rand_stamp());
  endtask

  task automatic test_directed();
    ranging_evt_t ev;
    send_simple(FUNC_TICK, '0);
    send_simple(FUNC_TX_DONE, '1);
    send_simple(FUNC_UNUSED, '1);
    send_frame(MSG_RANGE, '0);
    send_frame(8'hFF, '0);
    send_frame(MSG_POLL, '1);
    send_simple(FUNC_TX_DONE, '0);
    ev = random_evt();
    ev.func = FUNC_FRAME;
    ev.msg = MSG_RANGE;
    ev.now = '1;
    ev.t_poll = '0;
    ev.t_range = '1;
    for (int i = 0; i < 4; i++) ev.slot[i] = '1;
    send_event(ev);
    send_frame(MSG_POLL, 40'h12_3456_789A);
    send_frame(MSG_POLL, 40'h12_3456_789B);
    send_simple(FUNC_TX_DONE, 40'h12_3460_0000);
    send_frame(8'h80, '0);
    send_frame(MSG_RANGE, '0);
    // all four intervals zero
    send_frame(MSG_POLL, 40'hAB_CDEF_0123);
    send_simple(FUNC_TX_DONE, 40'hAB_CDEF_0123);
    ev.func = FUNC_FRAME;
    ev.msg = MSG_RANGE;
    ev.now = 40'hAB_CDEF_0123;
    ev.t_poll = 40'h55_5555_5555;
    ev.t_range = 40'h55_5555_5555;
    ev.slot[anchor_sel] = 40'h55_5555_5555;
    send_event(ev);
    run_exchange();
    quiesce();
  endtask

  task automatic test_idle_timeout();
    configure(2'd1, 16'd1);
    send_frame(MSG_POLL, 40'h00_0000_1000);
    send_simple(FUNC_TICK, '0);
    send_simple(FUNC_TICK, '0);
    send_frame(MSG_RANGE, 40'h00_0000_2000);
    quiesce();
  endtask

  task automatic test_long_timeout();
    ranging_evt_t ev;
    logic [SW-1:0] base;
    configure(2'd2, 16'hFFFF);
    base = rand_stamp();
    send_frame(MSG_POLL, base);
    send_simple(FUNC_TX_DONE, base + SW'(5000));
    ev = random_evt();
    ev.func = FUNC_TICK;
    repeat (40) send_event(ev);
    ev.func = FUNC_FRAME;
    ev.msg = MSG_RANGE;
    ev.t_poll = base;
    ev.slot[anchor_sel] = base + SW'(5400);
    ev.t_range = base + SW'(9000);
    ev.now = base + SW'(8800);
    send_event(ev);
    quiesce();
  endtask

  task automatic test_random_phase(input logic [1:0] idx_val, input logic [15:0] tmo,
                                   input int unsigned snd_pct, input int unsigned rcv_pct,
                                   input int unsigned n_items);
    int unsigned stop_at;
    configure(idx_val, tmo);
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 99) < 80) run_exchange();
      else repeat ($urandom_range(1, 3)) send_event(random_evt());
    end
    quiesce();
  endtask

  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    rcv_hold = 800;
    repeat (12) run_exchange();
    quiesce();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idle_timeout();
    test_long_timeout();
    test_random_phase(2'd1, 16'd300,   0,  0,  190);
    test_random_phase(2'd0, 16'd1,     75, 0,  190);
    test_random_phase(2'd3, 16'hFFFF,  0,  75, 190);
    test_random_phase(2'd2, 16'd5,     6,  6,  190);
    test_backpressure();
    test_random_phase(2'd3, 16'd2,     0,  0,  190);
    test_random_phase(2'd0, 16'hFFFF,  75, 0,  190);
    test_random_phase(2'd2, 16'd1,     0,  75, 190);
    test_random_phase(2'd1, 16'd300,   6,  6,  190);
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
